>>> rtl/bsag_pkg.sv
// ----------------------------------------------------------------------------
// bsag_pkg
// Shared types and constants of the broadcast source address generator.
// ----------------------------------------------------------------------------
package bsag_pkg;

    localparam int IDX_W     = 64;   // linear index width
    localparam int PACK_W    = 64;   // packed sizes, strides and coordinates
    localparam int OFS_W     = 36;   // source offset width
    localparam int RANK_W    = 3;    // rank register width
    localparam int CFG_IDX_W = 3;    // configuration register index width

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_RANK     = 2'd2,
        ST_ZERO     = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_RANK    = 3'd0,
        CFG_SRC_RANK    = 3'd1,
        CFG_OUT_SIZES   = 3'd2,
        CFG_SRC_SIZES   = 3'd3,
        CFG_SRC_STRIDES = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MAC,
        S_HOLD
    } t_state;

    // one dividend/quotient bit travelling along the divider row
    typedef struct packed {
        logic en;
        logic qbit;
    } t_link;

endpackage

>>> rtl/bsag_cell.sv
// ----------------------------------------------------------------------------
// bsag_cell
// Bit-serial restoring divider cell: takes dividend bits MSB first, keeps
// the remainder and passes quotient bits to the next cell.
// ----------------------------------------------------------------------------
module bsag_cell #(
    parameter int DIM_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  bsag_pkg::t_link       i_link,
    input  logic [DIM_BITS-1:0]   i_size,
    output bsag_pkg::t_link       o_link,
    output logic [DIM_BITS-1:0]   o_rem
);
    import bsag_pkg::*;

    t_link               r_link;
    logic [DIM_BITS-1:0] r_rem;
    logic [DIM_BITS:0]   w_part;
    logic                w_ge;
    logic [DIM_BITS:0]   w_diff;

    assign w_part = {r_rem, i_link.qbit};
    assign w_ge   = (w_part >= {1'b0, i_size});
    assign w_diff = w_part - {1'b0, i_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= '{en: i_link.en, qbit: i_link.en & w_ge};
        end
    end

    // partial remainder: clear per item, advance on each enabled bit
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_rem <= '0;
        end else if (i_link.en) begin
            r_rem <= w_ge ? w_diff[DIM_BITS-1:0] : w_part[DIM_BITS-1:0];
        end
    end

    assign o_link = r_link;
    assign o_rem  = r_rem;

endmodule

>>> rtl/broadcast_source_address_generator.sv
// ----------------------------------------------------------------------------
// broadcast_source_address_generator
// Maps a linear index of a broadcast output tensor to a source offset.
// ----------------------------------------------------------------------------
// One item at a time. The 64-bit index is shifted MSB first into a row of
// MAX_DIMS divider cells, innermost dimension first; each cell divides the
// bit stream by its dimension size and hands its quotient bits to the next
// cell through a register, keeping the coordinate as its remainder. Then
// come the multiply-accumulate steps (one coordinate times stride each
// cycle) and the load of the result register, which waits while the
// output is stalled. The next beat is taken in the idle cycle that follows
// the load, even while the loaded result still waits on a stalled output.
// Input is stalled in reset.
// ----------------------------------------------------------------------------
module broadcast_source_address_generator #(
    parameter int MAX_DIMS = 4,
    parameter int DIM_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bsag_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsag_pkg::PACK_W-1:0]     i_cfg_data,
    // input beat
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bsag_pkg::IDX_W-1:0]      i_linear_index,
    // result beat
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [bsag_pkg::OFS_W-1:0]      o_src_offset,
    output logic [bsag_pkg::PACK_W-1:0]     o_out_coords_packed,
    output logic [1:0]                      o_status
);
    import bsag_pkg::*;

    localparam int CNT_W = $clog2(IDX_W + MAX_DIMS);
    localparam int KW    = $clog2(MAX_DIMS + 1);
    localparam int CW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int PR_W  = 2 * DIM_BITS;

    // every dimension size 1
    localparam logic [PACK_W-1:0] SIZES_RST =
        PACK_W'({MAX_DIMS{{{(DIM_BITS-1){1'b0}}, 1'b1}}});

    // configuration registers
    logic [RANK_W-1:0] r_out_rank;
    logic [RANK_W-1:0] r_src_rank;
    logic [PACK_W-1:0] r_out_sizes;
    logic [PACK_W-1:0] r_src_sizes;
    logic [PACK_W-1:0] r_src_strides;

    // control
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [KW-1:0]     r_k;
    logic [IDX_W-1:0]  r_idx;
    logic [PR_W-1:0]   r_prod;
    logic [OFS_W-1:0]  r_acc;
    logic              r_mis;

    // result register
    logic              r_o_valid;
    logic [OFS_W-1:0]  r_o_offset;
    logic [PACK_W-1:0] r_o_coords;
    t_status           r_o_status;

    // decoded control
    logic w_accept, w_feed, w_div_last, w_mac, w_mac_last, w_load, w_out_free;

    logic [RANK_W-1:0]   w_orank;
    logic                w_rank_err, w_zero_err;
    logic [DIM_BITS-1:0] w_cell_size [MAX_DIMS];
    logic [DIM_BITS-1:0] w_rem       [MAX_DIMS];
    t_link               w_link      [MAX_DIMS+1];
    logic [PACK_W-1:0]   w_coords;
    logic [RANK_W-1:0]   w_cidx;
    logic [DIM_BITS-1:0] w_coord, w_ssz, w_stride;
    logic                w_k_act;

    assign o_cfg_ready = 1'b1;

    // ---- configuration writes ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_rank    <= RANK_W'(1);
            r_src_rank    <= '0;
            r_out_sizes   <= SIZES_RST;
            r_src_sizes   <= SIZES_RST;
            r_src_strides <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_OUT_RANK:    r_out_rank    <= i_cfg_data[RANK_W-1:0];
                CFG_SRC_RANK:    r_src_rank    <= i_cfg_data[RANK_W-1:0];
                CFG_OUT_SIZES:   r_out_sizes   <= i_cfg_data;
                CFG_SRC_SIZES:   r_src_sizes   <= i_cfg_data;
                CFG_SRC_STRIDES: r_src_strides <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- rank checks ----
    assign w_orank    = (r_out_rank > RANK_W'(MAX_DIMS)) ? RANK_W'(MAX_DIMS) : r_out_rank;
    assign w_rank_err = (r_src_rank > w_orank);

    always_comb begin
        w_zero_err = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if ((RANK_W'(d) < w_orank) && (r_out_sizes[d*DIM_BITS +: DIM_BITS] == '0)) begin
                w_zero_err = 1'b1;
            end
        end
    end

    // cell c divides by the size of output dimension orank-1-c
    always_comb begin
        for (int c = 0; c < MAX_DIMS; c++) begin
            w_cell_size[c] = DIM_BITS'(1);
            if (RANK_W'(c) < w_orank) begin
                w_cell_size[c] = r_out_sizes[(int'(w_orank) - 1 - c)*DIM_BITS +: DIM_BITS];
            end
        end
    end

    // ---- state machine ----
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_accept   = i_valid && !o_stall;
    assign w_div_last = (r_cnt == CNT_W'(IDX_W + MAX_DIMS - 2));
    assign w_mac_last = (r_k == KW'(MAX_DIMS));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid)    n_state = S_DIV;
            S_DIV:  if (w_div_last) n_state = S_MAC;
            S_MAC:  if (w_mac_last) n_state = S_HOLD;
            S_HOLD: if (w_out_free) n_state = S_IDLE;
            default:                n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != S_IDLE) || !i_rst_n;
        w_feed  = (r_state == S_DIV) && (r_cnt < CNT_W'(IDX_W));
        w_mac   = (r_state == S_MAC);
        w_load  = (r_state == S_HOLD) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---- index shifter and step counters ----
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx <= i_linear_index;
            r_cnt <= '0;
            r_k   <= '0;
        end else begin
            if (w_feed) begin
                r_idx <= {r_idx[IDX_W-2:0], 1'b0};
            end
            if (r_state == S_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (w_mac) begin
                r_k <= r_k + KW'(1);
            end
        end
    end

    // ---- divider row ----
    assign w_link[0] = '{en: w_feed, qbit: r_idx[IDX_W-1]};

    for (genvar c = 0; c < MAX_DIMS; c++) begin : g_cell
        bsag_cell #(
            .DIM_BITS (DIM_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_accept),
            .i_link  (w_link[c]),
            .i_size  (w_cell_size[c]),
            .o_link  (w_link[c+1]),
            .o_rem   (w_rem[c])
        );
    end

    // ---- multiply-accumulate over source dimensions ----
    // source dim k lines up with output dim skip+k, held in cell srank-1-k
    assign w_k_act  = (r_k < KW'(MAX_DIMS)) && (RANK_W'(r_k) < r_src_rank);
    assign w_cidx   = r_src_rank - RANK_W'(1) - RANK_W'(r_k);
    assign w_coord  = w_rem[w_cidx[CW-1:0]];
    assign w_ssz    = r_src_sizes[r_k*DIM_BITS +: DIM_BITS];
    assign w_stride = r_src_strides[r_k*DIM_BITS +: DIM_BITS];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prod <= '0;
            r_acc  <= '0;
            r_mis  <= 1'b0;
        end else if (w_mac) begin
            r_acc  <= r_acc + OFS_W'(r_prod);
            r_prod <= '0;
            if (w_k_act) begin
                if (w_coord >= w_ssz) begin
                    // out of range: adds nothing, flag unless a true broadcast
                    if (w_ssz != DIM_BITS'(1)) begin
                        r_mis <= 1'b1;
                    end
                end else begin
                    r_prod <= w_coord * w_stride;
                end
            end
        end
    end

    // ---- coordinate packing ----
    always_comb begin
        w_coords = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (RANK_W'(d) < w_orank) begin
                w_coords[d*DIM_BITS +: DIM_BITS] = w_rem[int'(w_orank) - 1 - d];
            end
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_rank_err) begin
                r_o_status <= ST_RANK;
                r_o_offset <= '0;
                r_o_coords <= '0;
            end else if (w_zero_err) begin
                r_o_status <= ST_ZERO;
                r_o_offset <= '0;
                r_o_coords <= '0;
            end else begin
                r_o_status <= r_mis ? ST_MISMATCH : ST_OK;
                r_o_offset <= r_acc;
                r_o_coords <= w_coords;
            end
        end
    end

    assign o_valid             = r_o_valid;
    assign o_src_offset        = r_o_offset;
    assign o_out_coords_packed = r_o_coords;
    assign o_status            = r_o_status;

`ifndef NO_ASSERTIONS
    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_DIV && r_cnt == '0))
        else $error("accepted beat did not start the divider");

    a_feed_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[0].en |-> (r_state == S_DIV))
        else $error("divider fed outside the divide phase");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !(r_o_valid && i_stall))
        else $error("result overwritten while stalled");

    a_rank_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_RANK) |-> (o_src_offset == '0 && o_out_coords_packed == '0))
        else $error("rank error result not cleared");
`endif

endmodule
